### design/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CHK_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define CHK_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/fclr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fclr_pkg;

    localparam int MAX_POINTS_DEF = 16;

    localparam logic [7:0] TEMP_CEILING  = 8'd100;
    localparam logic [7:0] TEMP_FLOOR    = 8'd0;
    localparam logic [6:0] SPEED_CEILING = 7'd100;
    localparam logic [6:0] SPEED_FLOOR   = 7'd0;

    // request kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_POINT = 2'd1;
    localparam logic [1:0] KIND_MODE  = 2'd2;

    // trend codes
    localparam logic [1:0] TREND_STABLE = 2'd0;
    localparam logic [1:0] TREND_RISE   = 2'd1;
    localparam logic [1:0] TREND_FALL   = 2'd2;

    // register indexes
    localparam logic [2:0] REG_RISE_DELAY   = 3'd0;
    localparam logic [2:0] REG_FALL_DELAY   = 3'd1;
    localparam logic [2:0] REG_MAX_RISE_LAG = 3'd2;
    localparam logic [2:0] REG_MAX_FALL_LAG = 3'd3;
    localparam logic [2:0] REG_POINTS       = 3'd4;

    localparam int PADDR_W = 5;
    localparam int NUM_W   = 15;   // |dy| * |dr| magnitude
    localparam int CNT_W   = 4;

    typedef struct packed {
        logic [15:0] rise_delay;
        logic [15:0] fall_delay;
        logic [7:0]  max_rise_lag;
        logic [7:0]  max_fall_lag;
        logic [4:0]  points_in_use;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic step_idx;
        logic grab_first;
        logic grab_second;
        logic div_step;
        logic set_hit;
        logic set_interp;
        logic set_none;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_lookup;
        logic skip;
        logic hit;
        logic at_end;
        logic div_last;
    } stat_t;

endpackage
`default_nettype wire

### design/fclr_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module fclr_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fclr_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output fclr_pkg::cfg_t                     cfg
);

    fclr_pkg::cfg_t cfg_reg, cfg_next;
    logic [2:0]     ridx;
    logic           wr_en;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];
    assign wr_en  = psel && penable && pwrite && pready && (paddr[1:0] == 2'b00);
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (ridx)
                fclr_pkg::REG_RISE_DELAY:   cfg_next.rise_delay    = pwdata[15:0];
                fclr_pkg::REG_FALL_DELAY:   cfg_next.fall_delay    = pwdata[15:0];
                fclr_pkg::REG_MAX_RISE_LAG: cfg_next.max_rise_lag  = pwdata[7:0];
                fclr_pkg::REG_MAX_FALL_LAG: cfg_next.max_fall_lag  = pwdata[7:0];
                fclr_pkg::REG_POINTS:       cfg_next.points_in_use = pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'b00) begin
            unique case (ridx)
                fclr_pkg::REG_RISE_DELAY:   prdata = {16'd0, cfg_reg.rise_delay};
                fclr_pkg::REG_FALL_DELAY:   prdata = {16'd0, cfg_reg.fall_delay};
                fclr_pkg::REG_MAX_RISE_LAG: prdata = {24'd0, cfg_reg.max_rise_lag};
                fclr_pkg::REG_MAX_FALL_LAG: prdata = {24'd0, cfg_reg.max_fall_lag};
                fclr_pkg::REG_POINTS:       prdata = {27'd0, cfg_reg.points_in_use};
                default:                    prdata = 32'd0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rise_delay    <= 16'd5;
            cfg_reg.fall_delay    <= 16'd5;
            cfg_reg.max_rise_lag  <= 8'd5;
            cfg_reg.max_fall_lag  <= 8'd5;
            cfg_reg.points_in_use <= 5'd2;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

### design/fclr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module fclr_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    input  wire logic [1:0]      s_kind,
    input  fclr_pkg::stat_t      stat,
    output fclr_pkg::cmd_t       cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_PAIR = 6'b000100,
        S_DIV  = 6'b001000,
        S_FIN  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   lookup_kind;

    assign s_tready    = (state_reg == S_IDLE);
    assign m_tvalid    = m_valid_reg;
    assign lookup_kind = (s_kind == fclr_pkg::KIND_TICK) || (s_kind == fclr_pkg::KIND_MODE);

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = lookup_kind ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                priority if (stat.skip && stat.at_end) begin
                    cmd.set_none = 1'b1;
                    state_next   = S_DONE;
                end else if (stat.skip) begin
                    cmd.step_idx = 1'b1;
                end else if (stat.hit) begin
                    cmd.set_hit = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    cmd.grab_first = 1'b1;
                    state_next     = S_PAIR;
                end
            end
            S_PAIR: begin
                cmd.grab_second = 1'b1;
                state_next      = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) state_next = S_FIN;
            end
            S_FIN: begin
                cmd.set_interp = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

### design/fclr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module fclr_dp #(
    parameter int MAX_POINTS = fclr_pkg::MAX_POINTS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  fclr_pkg::cfg_t       cfg,
    input  fclr_pkg::cmd_t       cmd,
    output fclr_pkg::stat_t      stat,
    input  wire logic [1:0]      s_kind,
    input  wire logic [7:0]      s_sample_temp,
    input  wire logic [3:0]      s_point_index,
    input  wire logic [7:0]      s_point_temp,
    input  wire logic [7:0]      s_point_speed,
    output logic      [6:0]      m_fan_speed,
    output logic      [7:0]      m_reference_temp,
    output logic      [1:0]      m_trend,
    output logic                 m_no_point_found
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int N_W   = IDX_W + 1;

    // tracker state
    logic [7:0]  ref_reg, ref_next;
    logic [1:0]  trend_reg, trend_next;
    logic [15:0] wait_reg, wait_next;
    logic        moving_reg, moving_next;

    // point table
    logic [7:0]  tbl_temp_reg  [MAX_POINTS];
    logic [6:0]  tbl_speed_reg [MAX_POINTS];

    // search and interpolation
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [7:0]            x1_reg;
    logic [6:0]            y1_reg;
    logic [7:0]            den_reg;
    logic [8:0]            rem_reg;
    logic [fclr_pkg::NUM_W-1:0] num_reg;
    logic                  neg_reg;
    logic [fclr_pkg::CNT_W-1:0] cnt_reg;
    logic [6:0]            speed_reg;
    logic                  npf_reg;
    logic                  lookup_reg;

    logic [6:0]  out_speed_reg;
    logic [7:0]  out_ref_reg;
    logic [1:0]  out_trend_reg;
    logic        out_npf_reg;

    // ---- tick update ----
    logic [7:0]  t;
    logic [7:0]  r0;
    logic [1:0]  tr0;
    logic [15:0] w0;
    logic        m0;
    logic [1:0]  dir;
    logic        is_lookup_kind;

    assign t = (s_sample_temp >= fclr_pkg::TEMP_CEILING) ?
               fclr_pkg::TEMP_CEILING - 8'd1 : s_sample_temp;
    assign is_lookup_kind = (s_kind == fclr_pkg::KIND_TICK) || (s_kind == fclr_pkg::KIND_MODE);

    always_comb begin
        if (s_kind == fclr_pkg::KIND_MODE) begin
            r0 = t; tr0 = fclr_pkg::TREND_STABLE; w0 = 16'd0; m0 = 1'b0;
        end else begin
            r0 = ref_reg; tr0 = trend_reg; w0 = wait_reg; m0 = moving_reg;
        end
        dir         = (t > r0) ? fclr_pkg::TREND_RISE : fclr_pkg::TREND_FALL;
        ref_next    = r0;
        trend_next  = tr0;
        wait_next   = w0;
        moving_next = m0;
        if (t == r0) begin
            trend_next  = fclr_pkg::TREND_STABLE;
            moving_next = 1'b0;
        end else begin
            if (tr0 != dir) begin
                trend_next  = dir;
                moving_next = 1'b0;
                wait_next   = (dir == fclr_pkg::TREND_RISE) ? cfg.rise_delay : cfg.fall_delay;
            end
            if (!moving_next) begin
                if (wait_next <= 16'd1) begin
                    wait_next   = 16'd0;
                    moving_next = 1'b1;
                end else begin
                    wait_next = wait_next - 16'd1;
                end
            end
            if (dir == fclr_pkg::TREND_RISE) begin
                if ((t - r0) > cfg.max_rise_lag) ref_next = t - cfg.max_rise_lag;
                else if (moving_next)            ref_next = r0 + 8'd1;
            end else begin
                // the jump above the sample wraps at eight bits
                if ((r0 - t) > cfg.max_fall_lag) ref_next = t + cfg.max_fall_lag;
                else if (moving_next)            ref_next = r0 - 8'd1;
            end
        end
    end

    // ---- point access ----
    logic [N_W:0]     n_pts;
    logic [IDX_W-1:0] last_idx;
    logic             dflt_line;
    logic [7:0]       px_raw, px;
    logic [6:0]       py_raw, py;
    logic             rising;

    assign dflt_line = (cfg.points_in_use < 5'd2);
    always_comb begin
        if (dflt_line)
            n_pts = (N_W+1)'(2);
        else if ((N_W+1)'(cfg.points_in_use) > (N_W+1)'(MAX_POINTS))
            n_pts = (N_W+1)'(MAX_POINTS);
        else
            n_pts = (N_W+1)'(cfg.points_in_use);
    end
    assign last_idx = IDX_W'(n_pts - (N_W+1)'(1));
    assign rising   = (trend_reg == fclr_pkg::TREND_RISE);

    always_comb begin
        px_raw = tbl_temp_reg[idx_reg];
        py_raw = tbl_speed_reg[idx_reg];
        if (dflt_line) begin
            px = (idx_reg == '0) ? fclr_pkg::TEMP_FLOOR  : fclr_pkg::TEMP_CEILING;
            py = (idx_reg == '0) ? fclr_pkg::SPEED_FLOOR : fclr_pkg::SPEED_CEILING;
        end else begin
            if (idx_reg == '0)            px_raw = fclr_pkg::TEMP_FLOOR;
            else if (idx_reg == last_idx) px_raw = fclr_pkg::TEMP_CEILING;
            if (px_raw > fclr_pkg::TEMP_CEILING)     px = fclr_pkg::TEMP_CEILING;
            else if (px_raw < fclr_pkg::TEMP_FLOOR)  px = fclr_pkg::TEMP_FLOOR;
            else                                     px = px_raw;
            if (py_raw > fclr_pkg::SPEED_CEILING)    py = fclr_pkg::SPEED_CEILING;
            else if (py_raw < fclr_pkg::SPEED_FLOOR) py = fclr_pkg::SPEED_FLOOR;
            else                                     py = py_raw;
        end
    end

    assign stat.is_lookup = lookup_reg;
    assign stat.skip      = rising ? (px > ref_reg) : (px < ref_reg);
    assign stat.hit       = (px == ref_reg) || (rising ? (idx_reg == last_idx) : (idx_reg == '0));
    assign stat.at_end    = rising ? (idx_reg == '0) : (idx_reg == last_idx);
    assign stat.div_last  = (cnt_reg == fclr_pkg::CNT_W'(fclr_pkg::NUM_W - 1));

    always_comb begin
        idx_next = idx_reg;
        if (cmd.accept)
            idx_next = (trend_next == fclr_pkg::TREND_RISE) ? last_idx : '0;
        else if (cmd.step_idx || cmd.grab_first)
            idx_next = rising ? idx_reg - IDX_W'(1) : idx_reg + IDX_W'(1);
        // scan moves away from the matched side; the pair neighbor is the other way
        if (cmd.grab_first)
            idx_next = rising ? idx_reg + IDX_W'(1) : idx_reg - IDX_W'(1);
    end

    // ---- interpolation ----
    logic signed [8:0] dy, dr, dx;
    logic [6:0]        ady;
    logic [7:0]        adr, adx;
    logic [8:0]        rem_sh;
    logic              qbit;

    assign dy  = 9'(signed'({2'b00, py})) - 9'(signed'({2'b00, y1_reg}));
    assign dr  = 9'(signed'({1'b0, ref_reg})) - 9'(signed'({1'b0, x1_reg}));
    assign dx  = 9'(signed'({1'b0, px})) - 9'(signed'({1'b0, x1_reg}));
    assign ady = dy[8] ? 7'(-dy) : 7'(dy);
    assign adr = dr[8] ? 8'(-dr) : 8'(dr);
    assign adx = dx[8] ? 8'(-dx) : 8'(dx);

    assign rem_sh = {rem_reg[7:0], num_reg[fclr_pkg::NUM_W-1]};
    assign qbit   = (rem_sh >= {1'b0, den_reg});

    logic [7:0] tw_temp;
    logic [6:0] tw_speed;
    logic [6:0] widx;

    assign widx = {3'd0, s_point_index};
    always_comb begin
        if (s_point_temp > fclr_pkg::TEMP_CEILING)     tw_temp = fclr_pkg::TEMP_CEILING;
        else if (s_point_temp < fclr_pkg::TEMP_FLOOR)  tw_temp = fclr_pkg::TEMP_FLOOR;
        else                                           tw_temp = s_point_temp;
        if (s_point_speed > {1'b0, fclr_pkg::SPEED_CEILING})
            tw_speed = fclr_pkg::SPEED_CEILING;
        else if (s_point_speed < {1'b0, fclr_pkg::SPEED_FLOOR})
            tw_speed = fclr_pkg::SPEED_FLOOR;
        else
            tw_speed = s_point_speed[6:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg    <= 8'd0;
            trend_reg  <= fclr_pkg::TREND_STABLE;
            wait_reg   <= 16'd0;
            moving_reg <= 1'b0;
            lookup_reg <= 1'b0;
            for (int i = 0; i < MAX_POINTS; i++) begin
                tbl_temp_reg[i]  <= 8'd0;
                tbl_speed_reg[i] <= 7'd0;
            end
        end else if (cmd.accept) begin
            lookup_reg <= is_lookup_kind;
            if (is_lookup_kind) begin
                ref_reg    <= ref_next;
                trend_reg  <= trend_next;
                wait_reg   <= wait_next;
                moving_reg <= moving_next;
            end else if (s_kind == fclr_pkg::KIND_POINT && widx < 7'(MAX_POINTS)) begin
                tbl_temp_reg[widx[IDX_W-1:0]]  <= tw_temp;
                tbl_speed_reg[widx[IDX_W-1:0]] <= tw_speed;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.accept) begin
            speed_reg <= 7'd0;
            npf_reg   <= 1'b0;
        end
        if (cmd.set_hit)  speed_reg <= py;
        if (cmd.set_none) begin
            speed_reg <= 7'd0;
            npf_reg   <= 1'b1;
        end
        if (cmd.grab_first) begin
            x1_reg <= px;
            y1_reg <= py;
        end
        if (cmd.grab_second) begin
            num_reg <= {8'd0, ady} * {7'd0, adr};
            den_reg <= adx;
            neg_reg <= dy[8];
            rem_reg <= 9'd0;
            cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= qbit ? rem_sh - {1'b0, den_reg} : rem_sh;
            num_reg <= {num_reg[fclr_pkg::NUM_W-2:0], qbit};
            cnt_reg <= cnt_reg + fclr_pkg::CNT_W'(1);
        end
        if (cmd.set_interp)
            speed_reg <= neg_reg ? y1_reg - num_reg[6:0] : y1_reg + num_reg[6:0];
        if (cmd.out_load) begin
            out_speed_reg <= speed_reg;
            out_ref_reg   <= ref_reg;
            out_trend_reg <= trend_reg;
            out_npf_reg   <= npf_reg;
        end
    end

    assign m_fan_speed      = out_speed_reg;
    assign m_reference_temp = out_ref_reg;
    assign m_trend          = out_trend_reg;
    assign m_no_point_found = out_npf_reg;

endmodule
`default_nettype wire

### design/fan_curve_lagged_reference_top.sv
// lagged-reference fan curve controller
//
// input channel s_*: one request per item; s_tuser holds the kind (tick, point
// write, curve mode entry), s_tdata the sample and the point fields
// result channel m_*: one result per request, fan speed, reference temperature,
// trend in m_tdata and the no-point flag in m_tuser
// apb port: five config registers at byte addresses 0,4,..,16, write only when idle
//
// a point write or an unknown kind goes straight to the final step after acceptance
// a tick or a curve mode entry walks the point table one entry per cycle; a hit
// or a walk that ends with no point goes straight to the final step, else the block
// fetches the bracketing pair, runs the restoring divider, adds and loads the
// result register; the next request can be taken once the result is loaded
// one request is worked on at a time; s_tready is high only while idle
// the result register lets the next request in while a result still waits
// reset clears the tracker, the point table, the registers to their defaults
// and m_tvalid; a stalled receiver holds m_tdata and the block waits in its
// final step until the result register frees
`timescale 1ns / 1ps
`default_nettype none
module fan_curve_lagged_reference_top #(
    parameter int MAX_POINTS = fclr_pkg::MAX_POINTS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // request channel
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [7:0] sample_temp, [11:8] point_index, [19:12] point_temp,
    // [27:20] point_speed, [31:28] zero
    input  wire logic [31:0]                   s_tdata,
    // [1:0] kind
    input  wire logic [1:0]                    s_tuser,
    // result channel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [6:0] fan_speed, [14:7] reference_temp, [16:15] trend, [23:17] zero
    output logic      [23:0]                   m_tdata,
    // [0] no_point_found
    output logic                               m_tuser,
    // config port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fclr_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    fclr_pkg::cfg_t  cfg;
    fclr_pkg::cmd_t  cmd;
    fclr_pkg::stat_t stat;

    logic [6:0] fan_speed;
    logic [7:0] reference_temp;
    logic [1:0] trend;
    logic       no_point_found;

    // register file
    fclr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: accept, table walk, divide, result hand-off
    fclr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .s_kind   (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // tracker state, point table, divider and result register
    fclr_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .cmd              (cmd),
        .stat             (stat),
        .s_kind           (s_tuser),
        .s_sample_temp    (s_tdata[7:0]),
        .s_point_index    (s_tdata[11:8]),
        .s_point_temp     (s_tdata[19:12]),
        .s_point_speed    (s_tdata[27:20]),
        .m_fan_speed      (fan_speed),
        .m_reference_temp (reference_temp),
        .m_trend          (trend),
        .m_no_point_found (no_point_found)
    );

    assign m_tdata = {7'd0, trend, reference_temp, fan_speed};
    assign m_tuser = no_point_found;

endmodule
`default_nettype wire

### design/fclr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fclr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [4:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    `CHK_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `CHK_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && m_tvalid, "stalled result changed")
    `CHK_ASSERT(a_speed_range, aclk, aresetn, m_tvalid |-> m_tdata[6:0] <= 7'd100 && m_tdata[16:15] != 2'd3, "result out of range")
    `CHK_ASSERT(a_none_zero, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata[6:0] == 7'd0, "speed set with no point")

endmodule

bind fan_curve_lagged_reference_top fclr_checker u_fclr_checker (.*);
`default_nettype wire
